/* src/hrhp_pkg.sv */
`timescale 1ns / 1ps

package hrhp_pkg;

    // Payload widths
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int HIDX_W   = 5;
    localparam int OFF_W    = 8;
    localparam int STATUS_W = 2;

    // Default limits
    localparam int METHOD_MAX_DEF     = 6;
    localparam int RESOURCE_MAX_DEF   = 129;
    localparam int NAME_MAX_DEF       = 32;
    localparam int VALUE_MAX_DEF      = 254;
    localparam int HEADER_ENTRIES_DEF = 32;

    // Length of the protocol version text
    localparam int VERSION_LEN = 8;

    // Input operation codes
    localparam logic [OP_W-1:0] OP_DATA   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSED = 2'd1;
    localparam logic [OP_W-1:0] OP_BEGIN  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Field kinds
    localparam logic [KIND_W-1:0] KIND_DELIM    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_METHOD   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESOURCE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NAME     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VALUE    = 3'd4;

    // Parse status
    localparam logic [STATUS_W-1:0] ST_RUN  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

    // Delimiter characters
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    typedef logic [BYTE_W-1:0] t_byte;

    // Expected character of the version text "HTTP/1.1"
    function automatic t_byte version_char(input logic [2:0] idx);
        t_byte c;
        case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2E;
            default: c = 8'h31;
        endcase
        return c;
    endfunction

endpackage

/* src/hrhp_if.sv */
`timescale 1ns / 1ps

// Input channel: one request byte or control op per word
interface hrhp_byte_if;
    logic                         valid;
    logic                         ready;
    logic [hrhp_pkg::OP_W-1:0]    op;
    logic [hrhp_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// Output channel: one tagged byte per word
interface hrhp_tag_if;
    logic                           valid;
    logic                           ready;
    logic [hrhp_pkg::KIND_W-1:0]    field_kind;
    logic [hrhp_pkg::HIDX_W-1:0]    header_index;
    logic [hrhp_pkg::OFF_W-1:0]     char_offset;
    logic [hrhp_pkg::BYTE_W-1:0]    char_value;
    logic [hrhp_pkg::STATUS_W-1:0]  parse_status;

    modport source (output valid, output field_kind, output header_index,
                    output char_offset, output char_value, output parse_status,
                    input ready);
    modport sink   (input valid, input field_kind, input header_index,
                    input char_offset, input char_value, input parse_status,
                    output ready);
endinterface

/* src/http_request_head_parser.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Fields                                                  | Word
// ---------+-----+---------------------------------------------------------+-------------
// i_byte   | in  | op, data_byte                                           | 1 byte/op
// o_tag    | out | field_kind, header_index, char_offset, char_value,      | 1 tag/word
//          |     | parse_status                                            |
//
// Every input word yields exactly one output word, through the input register and
// then the result register. One word per cycle is sustained while o_tag is ready;
// the phase/position/entry update is combinational between the two registers.
// Reset (i_rst_n low, synchronous) returns the parser to the method phase and
// empties both registers. A stall on o_tag backs up through the result and
// input registers; i_byte.ready drops only when both are full.

module http_request_head_parser #(
    parameter int METHOD_MAX     = hrhp_pkg::METHOD_MAX_DEF,
    parameter int RESOURCE_MAX   = hrhp_pkg::RESOURCE_MAX_DEF,
    parameter int NAME_MAX       = hrhp_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX      = hrhp_pkg::VALUE_MAX_DEF,
    parameter int HEADER_ENTRIES = hrhp_pkg::HEADER_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hrhp_byte_if.sink    i_byte,
    hrhp_tag_if.source   o_tag
);

    // Position counter covers the largest limit
    localparam int MAX_A   = (METHOD_MAX > RESOURCE_MAX) ? METHOD_MAX : RESOURCE_MAX;
    localparam int MAX_B   = (NAME_MAX > VALUE_MAX) ? NAME_MAX : VALUE_MAX;
    localparam int MAX_C   = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int POS_MAX = (MAX_C > hrhp_pkg::VERSION_LEN) ? MAX_C : hrhp_pkg::VERSION_LEN;
    localparam int POS_W   = $clog2(POS_MAX + 1);
    localparam int IDX_W   = (HEADER_ENTRIES > 1) ? $clog2(HEADER_ENTRIES) : 1;

    localparam logic [POS_W-1:0] LIM_METHOD   = POS_W'(METHOD_MAX);
    localparam logic [POS_W-1:0] LIM_RESOURCE = POS_W'(RESOURCE_MAX);
    localparam logic [POS_W-1:0] LIM_NAME     = POS_W'(NAME_MAX);
    localparam logic [POS_W-1:0] LIM_VALUE    = POS_W'(VALUE_MAX);
    localparam logic [POS_W-1:0] LIM_VERSION  = POS_W'(hrhp_pkg::VERSION_LEN);
    localparam logic [IDX_W-1:0] LAST_ENTRY   = IDX_W'(HEADER_ENTRIES - 1);

    // Phase codes
    localparam logic [3:0] PH_METHOD   = 4'd0;
    localparam logic [3:0] PH_RESOURCE = 4'd1;
    localparam logic [3:0] PH_VERSION  = 4'd2;
    localparam logic [3:0] PH_RL_CR    = 4'd3;
    localparam logic [3:0] PH_RL_LF    = 4'd4;
    localparam logic [3:0] PH_NAME     = 4'd5;
    localparam logic [3:0] PH_SPACE    = 4'd6;
    localparam logic [3:0] PH_VALUE    = 4'd7;
    localparam logic [3:0] PH_HDR_LF   = 4'd8;
    localparam logic [3:0] PH_AFTER    = 4'd9;
    localparam logic [3:0] PH_END_LF   = 4'd10;

    // Input register
    logic                           r_in_valid;
    logic [hrhp_pkg::OP_W-1:0]      r_in_op;
    logic [hrhp_pkg::BYTE_W-1:0]    r_in_byte;

    // Parser state
    logic [3:0]                     r_phase,  n_phase;
    logic [POS_W-1:0]               r_pos,    n_pos;
    logic [IDX_W-1:0]               r_entry,  n_entry;
    logic [hrhp_pkg::STATUS_W-1:0]  r_status, n_status;

    // Result register
    logic                           r_out_valid;
    logic [hrhp_pkg::KIND_W-1:0]    r_out_kind,   n_out_kind;
    logic [IDX_W-1:0]               r_out_idx,    n_out_idx;
    logic [POS_W-1:0]               r_out_off,    n_out_off;
    logic [hrhp_pkg::BYTE_W-1:0]    r_out_val,    n_out_val;
    logic [hrhp_pkg::STATUS_W-1:0]  r_out_status, n_out_status;

    logic             advance;
    logic             step;
    logic [POS_W-1:0] pos_inc;

    // Handshake: result register drains, input register refills behind it
    assign advance      = !r_out_valid || o_tag.ready;
    assign step         = r_in_valid && advance;
    assign i_byte.ready = !r_in_valid || advance;
    assign pos_inc      = r_pos + 1'b1;

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
        if (i_byte.ready && i_byte.valid) begin
            r_in_op   <= i_byte.op;
            r_in_byte <= i_byte.data_byte;
        end
    end

    // Parse step: next state and tag for the registered word
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_entry      = r_entry;
        n_status     = r_status;
        n_out_kind   = hrhp_pkg::KIND_DELIM;
        n_out_idx    = '0;
        n_out_off    = '0;
        n_out_val    = '0;
        n_out_status = r_status;

        unique case (r_in_op)
            hrhp_pkg::OP_BEGIN: begin
                n_phase      = PH_METHOD;
                n_pos        = '0;
                n_entry      = '0;
                n_status     = hrhp_pkg::ST_RUN;
                n_out_status = hrhp_pkg::ST_RUN;
            end
            hrhp_pkg::OP_CLOSED: begin
                if (r_status == hrhp_pkg::ST_RUN) begin
                    n_status     = hrhp_pkg::ST_ERR;
                    n_out_status = hrhp_pkg::ST_ERR;
                end
            end
            hrhp_pkg::OP_DATA: begin
                n_out_val = r_in_byte;
                if (r_status == hrhp_pkg::ST_RUN) begin
                    unique case (r_phase)
                        PH_METHOD: begin
                            if (r_in_byte == hrhp_pkg::CH_SPACE) begin
                                n_phase = PH_RESOURCE;
                                n_pos   = '0;
                            end else begin
                                n_out_kind = hrhp_pkg::KIND_METHOD;
                                n_out_off  = r_pos;
                                if (pos_inc == LIM_METHOD) begin
                                    n_phase = PH_RESOURCE;
                                    n_pos   = '0;
                                end else begin
                                    n_pos = pos_inc;
                                end
                            end
                        end
                        PH_RESOURCE: begin
                            if (r_in_byte == hrhp_pkg::CH_SPACE) begin
                                n_phase = PH_VERSION;
                                n_pos   = '0;
                            end else begin
                                n_out_kind = hrhp_pkg::KIND_RESOURCE;
                                n_out_off  = r_pos;
                                if (pos_inc == LIM_RESOURCE) begin
                                    n_phase = PH_VERSION;
                                    n_pos   = '0;
                                end else begin
                                    n_pos = pos_inc;
                                end
                            end
                        end
                        PH_VERSION: begin
                            if (r_in_byte != hrhp_pkg::version_char(r_pos[2:0])) begin
                                n_status     = hrhp_pkg::ST_ERR;
                                n_out_status = hrhp_pkg::ST_ERR;
                            end else begin
                                n_out_off = POS_W'(r_pos[2:0]);
                                if (pos_inc == LIM_VERSION) begin
                                    n_phase = PH_RL_CR;
                                    n_pos   = '0;
                                end else begin
                                    n_pos = pos_inc;
                                end
                            end
                        end
                        PH_RL_CR: begin
                            if (r_in_byte != hrhp_pkg::CH_CR) begin
                                n_status     = hrhp_pkg::ST_ERR;
                                n_out_status = hrhp_pkg::ST_ERR;
                            end else begin
                                n_phase = PH_RL_LF;
                            end
                        end
                        PH_RL_LF: begin
                            if (r_in_byte != hrhp_pkg::CH_LF) begin
                                n_status     = hrhp_pkg::ST_ERR;
                                n_out_status = hrhp_pkg::ST_ERR;
                            end else begin
                                n_phase = PH_NAME;
                                n_pos   = '0;
                                n_entry = '0;
                            end
                        end
                        PH_NAME: begin
                            n_out_idx = r_entry;
                            if (r_in_byte == hrhp_pkg::CH_COLON) begin
                                n_phase = PH_SPACE;
                            end else begin
                                n_out_kind = hrhp_pkg::KIND_NAME;
                                n_out_off  = r_pos;
                                n_pos      = pos_inc;
                                if (pos_inc == LIM_NAME) begin
                                    n_phase = PH_SPACE;
                                end
                            end
                        end
                        PH_SPACE: begin
                            if (r_in_byte != hrhp_pkg::CH_SPACE) begin
                                n_status     = hrhp_pkg::ST_ERR;
                                n_out_status = hrhp_pkg::ST_ERR;
                            end else begin
                                n_out_idx = r_entry;
                                n_phase   = PH_VALUE;
                                n_pos     = '0;
                            end
                        end
                        PH_VALUE: begin
                            n_out_idx = r_entry;
                            if (r_in_byte == hrhp_pkg::CH_CR) begin
                                n_phase = PH_HDR_LF;
                            end else begin
                                n_out_kind = hrhp_pkg::KIND_VALUE;
                                n_out_off  = r_pos;
                                n_pos      = pos_inc;
                                if (pos_inc == LIM_VALUE) begin
                                    n_phase = PH_HDR_LF;
                                end
                            end
                        end
                        PH_HDR_LF: begin
                            if (r_in_byte != hrhp_pkg::CH_LF) begin
                                n_status     = hrhp_pkg::ST_ERR;
                                n_out_status = hrhp_pkg::ST_ERR;
                            end else begin
                                n_out_idx = r_entry;
                                n_phase   = PH_AFTER;
                            end
                        end
                        PH_AFTER: begin
                            if (r_in_byte == hrhp_pkg::CH_CR) begin
                                n_out_idx = r_entry;
                                n_phase   = PH_END_LF;
                            end else if (r_entry == LAST_ENTRY) begin
                                // entry table full: finish the head here
                                n_status     = hrhp_pkg::ST_DONE;
                                n_out_status = hrhp_pkg::ST_DONE;
                            end else begin
                                // first name byte of the next entry
                                n_entry    = r_entry + 1'b1;
                                n_out_idx  = r_entry + 1'b1;
                                n_out_kind = hrhp_pkg::KIND_NAME;
                                n_pos      = POS_W'(1);
                                n_phase    = (LIM_NAME == POS_W'(1)) ? PH_SPACE : PH_NAME;
                            end
                        end
                        PH_END_LF: begin
                            if (r_in_byte != hrhp_pkg::CH_LF) begin
                                n_status     = hrhp_pkg::ST_ERR;
                                n_out_status = hrhp_pkg::ST_ERR;
                            end else begin
                                n_status     = hrhp_pkg::ST_DONE;
                                n_out_status = hrhp_pkg::ST_DONE;
                            end
                        end
                        default: begin
                            n_status     = hrhp_pkg::ST_ERR;
                            n_out_status = hrhp_pkg::ST_ERR;
                        end
                    endcase
                end
            end
            default: begin
                // unused op: report current status only
                n_out_status = r_status;
            end
        endcase
    end

    // Advance parser state once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_METHOD;
            r_pos    <= '0;
            r_entry  <= '0;
            r_status <= hrhp_pkg::ST_RUN;
        end else if (step) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_entry  <= n_entry;
            r_status <= n_status;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (step) begin
            r_out_kind   <= n_out_kind;
            r_out_idx    <= n_out_idx;
            r_out_off    <= n_out_off;
            r_out_val    <= n_out_val;
            r_out_status <= n_out_status;
        end
    end

    assign o_tag.valid        = r_out_valid;
    assign o_tag.field_kind   = r_out_kind;
    assign o_tag.header_index = hrhp_pkg::HIDX_W'(r_out_idx);
    assign o_tag.char_offset  = hrhp_pkg::OFF_W'(r_out_off);
    assign o_tag.char_value   = r_out_val;
    assign o_tag.parse_status = r_out_status;

`ifndef NO_ASSERTIONS
    // Done and error stay until a new request begins
    a_status_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != hrhp_pkg::ST_RUN && !(step && r_in_op == hrhp_pkg::OP_BEGIN))
        |=> r_status == $past(r_status))
        else $error("final status changed without a new request");

    // Tagged field bytes only appear while running
    a_kind_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != hrhp_pkg::KIND_DELIM)
        |-> r_out_status == hrhp_pkg::ST_RUN)
        else $error("field byte tagged with final status");

    // Method position stays below its limit
    a_method_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_METHOD) |-> r_pos < LIM_METHOD)
        else $error("method position out of range");

    // A stalled result holds the input word in place
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_op) && $stable(r_in_byte)))
        else $error("input word lost during stall");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    // Run control
    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 2000;
    localparam int TOTAL_WORDS  = 1650;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [8*hrhp_pkg::VERSION_LEN-1:0] VERSION_TEXT = "HTTP/1.1";

    // Parser phases tracked by the predictor
    typedef enum logic [3:0] {
        HP_METHOD, HP_RESOURCE, HP_VERSION, HP_REQ_CR, HP_REQ_LF, HP_NAME,
        HP_SEP, HP_VALUE, HP_HDR_LF, HP_NEXT, HP_TERM_LF
    } t_hp_phase;

    typedef struct packed {
        logic [hrhp_pkg::KIND_W-1:0]   kind;
        logic [hrhp_pkg::HIDX_W-1:0]   hidx;
        logic [hrhp_pkg::OFF_W-1:0]    off;
        hrhp_pkg::t_byte               val;
        logic [hrhp_pkg::STATUS_W-1:0] status;
    } t_tag;

    logic clk = 1'b0;
    logic rst_n;

    hrhp_byte_if byte_ch();
    hrhp_tag_if  tag_ch();

    http_request_head_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch),
        .o_tag   (tag_ch)
    );

    // Predictor state
    t_hp_phase                     parse_phase;
    int                            char_pos;
    int                            hdr_entry;
    logic [hrhp_pkg::STATUS_W-1:0] head_status;

    t_tag            expected_tags[$];
    hrhp_pkg::t_byte head_bytes[$];
    int              mismatch_count;
    int              sent_words;
    int              idle_cycles;
    bit              idle_on;
    bit              short_fields;
    int              stall_req;
    int              stall_seen;
    int              hold_left;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_parse();
        parse_phase = HP_METHOD;
        char_pos    = 0;
        hdr_entry   = 0;
        head_status = hrhp_pkg::ST_RUN;
    endfunction

    // Character i of the version text
    function automatic hrhp_pkg::t_byte text_byte(input int i);
        return hrhp_pkg::t_byte'(VERSION_TEXT >> (8 * (hrhp_pkg::VERSION_LEN - 1 - i)));
    endfunction

    // Tag one input word and advance the parse state
    function automatic t_tag tag_word(input logic [hrhp_pkg::OP_W-1:0] op,
                                      input hrhp_pkg::t_byte b);
        t_tag t;
        bit   bad;
        bit   in_method;
        int   lim;
        t.kind   = hrhp_pkg::KIND_DELIM;
        t.hidx   = '0;
        t.off    = '0;
        t.val    = '0;
        t.status = head_status;
        bad      = 1'b0;
        if (op == hrhp_pkg::OP_BEGIN) begin
            clear_parse();
            t.status = hrhp_pkg::ST_RUN;
            return t;
        end
        if (op == hrhp_pkg::OP_UNUSED)
            return t;
        if (op == hrhp_pkg::OP_CLOSED) begin
            if (head_status == hrhp_pkg::ST_RUN)
                head_status = hrhp_pkg::ST_ERR;
            t.status = head_status;
            return t;
        end
        t.val = b;
        // Echo bytes once the head is finished
        if (head_status != hrhp_pkg::ST_RUN)
            return t;
        case (parse_phase)
            HP_METHOD, HP_RESOURCE: begin
                in_method = (parse_phase == HP_METHOD);
                lim = in_method ? hrhp_pkg::METHOD_MAX_DEF : hrhp_pkg::RESOURCE_MAX_DEF;
                if (b != hrhp_pkg::CH_SPACE) begin
                    t.kind = in_method ? hrhp_pkg::KIND_METHOD : hrhp_pkg::KIND_RESOURCE;
                    t.off  = char_pos[hrhp_pkg::OFF_W-1:0];
                    char_pos++;
                end
                if (b == hrhp_pkg::CH_SPACE || char_pos >= lim) begin
                    parse_phase = in_method ? HP_RESOURCE : HP_VERSION;
                    char_pos    = 0;
                end
            end
            HP_VERSION: begin
                if (b != text_byte(char_pos)) begin
                    bad = 1'b1;
                end else begin
                    t.off = char_pos[hrhp_pkg::OFF_W-1:0];
                    char_pos++;
                    if (char_pos >= hrhp_pkg::VERSION_LEN) begin
                        parse_phase = HP_REQ_CR;
                        char_pos    = 0;
                    end
                end
            end
            HP_REQ_CR: begin
                if (b != hrhp_pkg::CH_CR) bad = 1'b1;
                else parse_phase = HP_REQ_LF;
            end
            HP_REQ_LF: begin
                if (b != hrhp_pkg::CH_LF) begin
                    bad = 1'b1;
                end else begin
                    parse_phase = HP_NAME;
                    char_pos    = 0;
                    hdr_entry   = 0;
                end
            end
            HP_NAME: begin
                t.hidx = hdr_entry[hrhp_pkg::HIDX_W-1:0];
                if (b == hrhp_pkg::CH_COLON) begin
                    parse_phase = HP_SEP;
                end else begin
                    t.kind = hrhp_pkg::KIND_NAME;
                    t.off  = char_pos[hrhp_pkg::OFF_W-1:0];
                    char_pos++;
                    if (char_pos >= hrhp_pkg::NAME_MAX_DEF)
                        parse_phase = HP_SEP;
                end
            end
            HP_SEP: begin
                t.hidx = hdr_entry[hrhp_pkg::HIDX_W-1:0];
                if (b != hrhp_pkg::CH_SPACE) begin
                    bad = 1'b1;
                end else begin
                    parse_phase = HP_VALUE;
                    char_pos    = 0;
                end
            end
            HP_VALUE: begin
                t.hidx = hdr_entry[hrhp_pkg::HIDX_W-1:0];
                if (b == hrhp_pkg::CH_CR) begin
                    parse_phase = HP_HDR_LF;
                end else begin
                    t.kind = hrhp_pkg::KIND_VALUE;
                    t.off  = char_pos[hrhp_pkg::OFF_W-1:0];
                    char_pos++;
                    if (char_pos >= hrhp_pkg::VALUE_MAX_DEF)
                        parse_phase = HP_HDR_LF;
                end
            end
            HP_HDR_LF: begin
                t.hidx = hdr_entry[hrhp_pkg::HIDX_W-1:0];
                if (b != hrhp_pkg::CH_LF) bad = 1'b1;
                else parse_phase = HP_NEXT;
            end
            HP_NEXT: begin
                if (b == hrhp_pkg::CH_CR) begin
                    t.hidx      = hdr_entry[hrhp_pkg::HIDX_W-1:0];
                    parse_phase = HP_TERM_LF;
                end else if (hdr_entry + 1 >= hrhp_pkg::HEADER_ENTRIES_DEF) begin
                    // Table full: the would-be next entry ends the head
                    head_status = hrhp_pkg::ST_DONE;
                    t.status    = hrhp_pkg::ST_DONE;
                end else begin
                    hdr_entry++;
                    char_pos    = 1;
                    parse_phase = (char_pos >= hrhp_pkg::NAME_MAX_DEF) ? HP_SEP : HP_NAME;
                    t.kind      = hrhp_pkg::KIND_NAME;
                    t.hidx      = hdr_entry[hrhp_pkg::HIDX_W-1:0];
                end
            end
            HP_TERM_LF: begin
                if (b != hrhp_pkg::CH_LF) begin
                    bad = 1'b1;
                end else begin
                    head_status = hrhp_pkg::ST_DONE;
                    t.status    = hrhp_pkg::ST_DONE;
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            head_status = hrhp_pkg::ST_ERR;
            t.kind      = hrhp_pkg::KIND_DELIM;
            t.hidx      = '0;
            t.off       = '0;
            t.status    = hrhp_pkg::ST_ERR;
        end
        return t;
    endfunction

    // Offer one word, log its tag, hold until accepted
    task automatic send_word(input logic [hrhp_pkg::OP_W-1:0] op, input hrhp_pkg::t_byte b);
        while (idle_on && $urandom_range(0, 99) < 21) begin
            @(negedge clk);
            byte_ch.valid <= 1'b0;
        end
        @(negedge clk);
        byte_ch.valid     <= 1'b1;
        byte_ch.op        <= op;
        byte_ch.data_byte <= b;
        sent_words++;
        expected_tags.push_back(tag_word(op, b));
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(hrhp_pkg::OP_DATA, hrhp_pkg::t_byte'(s[i]));
    endtask

    task automatic send_crlf();
        send_word(hrhp_pkg::OP_DATA, hrhp_pkg::CH_CR);
        send_word(hrhp_pkg::OP_DATA, hrhp_pkg::CH_LF);
    endtask

    function automatic hrhp_pkg::t_byte pick_byte(input hrhp_pkg::t_byte not_a,
                                                  input hrhp_pkg::t_byte not_b);
        hrhp_pkg::t_byte c;
        do
            c = hrhp_pkg::t_byte'($urandom_range(0, 255));
        while (c == not_a || c == not_b);
        return c;
    endfunction

    // Mostly short lengths, sometimes the bounds; always the shortest when asked
    function automatic int rand_len(input int maxlen, input int minlen);
        int r;
        int v;
        if (short_fields)
            return minlen;
        r = $urandom_range(0, 99);
        if (r < 4)
            return maxlen;
        if (r < 12)
            return minlen;
        v = minlen + $urandom_range(0, 7);
        return (v > maxlen) ? maxlen : v;
    endfunction

    // Append a field; a full-length field carries no terminator
    task automatic add_field(input int len, input int lim, input hrhp_pkg::t_byte avoid,
                             input hrhp_pkg::t_byte first_avoid,
                             input hrhp_pkg::t_byte term);
        for (int i = 0; i < len; i++)
            head_bytes.push_back(pick_byte(avoid, (i == 0) ? first_avoid : avoid));
        if (len < lim)
            head_bytes.push_back(term);
    endtask

    // Build a well-formed head with random content
    task automatic build_head(input int n_hdr, input bit long_mode);
        int len;
        head_bytes.delete();
        len = long_mode ? hrhp_pkg::METHOD_MAX_DEF : rand_len(hrhp_pkg::METHOD_MAX_DEF, 0);
        add_field(len, hrhp_pkg::METHOD_MAX_DEF, hrhp_pkg::CH_SPACE, hrhp_pkg::CH_SPACE,
                  hrhp_pkg::CH_SPACE);
        len = long_mode ? hrhp_pkg::RESOURCE_MAX_DEF : rand_len(hrhp_pkg::RESOURCE_MAX_DEF, 0);
        add_field(len, hrhp_pkg::RESOURCE_MAX_DEF, hrhp_pkg::CH_SPACE, hrhp_pkg::CH_SPACE,
                  hrhp_pkg::CH_SPACE);
        for (int i = 0; i < hrhp_pkg::VERSION_LEN; i++)
            head_bytes.push_back(text_byte(i));
        head_bytes.push_back(hrhp_pkg::CH_CR);
        head_bytes.push_back(hrhp_pkg::CH_LF);
        for (int h = 0; h < n_hdr; h++) begin
            len = (long_mode && h == 0) ? hrhp_pkg::NAME_MAX_DEF :
                  rand_len(hrhp_pkg::NAME_MAX_DEF, (h == 0) ? 0 : 1);
            // A CR may open only the first name
            add_field(len, hrhp_pkg::NAME_MAX_DEF, hrhp_pkg::CH_COLON,
                      (h == 0) ? hrhp_pkg::CH_COLON : hrhp_pkg::CH_CR, hrhp_pkg::CH_COLON);
            head_bytes.push_back(hrhp_pkg::CH_SPACE);
            len = (long_mode && h == 0) ? hrhp_pkg::VALUE_MAX_DEF :
                  rand_len(hrhp_pkg::VALUE_MAX_DEF, 0);
            add_field(len, hrhp_pkg::VALUE_MAX_DEF, hrhp_pkg::CH_CR, hrhp_pkg::CH_CR,
                      hrhp_pkg::CH_CR);
            head_bytes.push_back(hrhp_pkg::CH_LF);
        end
        if (n_hdr <= hrhp_pkg::HEADER_ENTRIES_DEF) begin
            head_bytes.push_back(hrhp_pkg::CH_CR);
            head_bytes.push_back(hrhp_pkg::CH_LF);
        end
    endtask

    // Begin, head, optional corruption, then trailing words
    task automatic send_request(input int n_hdr, input bit long_mode, input bit broken);
        int idx;
        send_word(hrhp_pkg::OP_BEGIN, hrhp_pkg::t_byte'($urandom_range(0, 255)));
        build_head(n_hdr, long_mode);
        if (broken) begin
            idx = $urandom_range(0, head_bytes.size() - 1);
            head_bytes[idx] = hrhp_pkg::t_byte'($urandom_range(0, 255));
        end
        foreach (head_bytes[i])
            send_word(hrhp_pkg::OP_DATA, head_bytes[i]);
        repeat ($urandom_range(0, 3))
            send_word(hrhp_pkg::OP_DATA, hrhp_pkg::t_byte'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            send_word(hrhp_pkg::OP_CLOSED, hrhp_pkg::t_byte'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
            send_word(hrhp_pkg::OP_UNUSED, hrhp_pkg::t_byte'($urandom_range(0, 255)));
    endtask

    task automatic send_noise(input int n);
        repeat (n)
            send_word(hrhp_pkg::OP_W'($urandom_range(0, 3)),
                      hrhp_pkg::t_byte'($urandom_range(0, 255)));
    endtask

    // Empty method, two-byte resource, CR as first name byte, colon opening a later name
    task automatic test_basic_head();
        send_word(hrhp_pkg::OP_BEGIN, 8'h00);
        send_word(hrhp_pkg::OP_DATA, hrhp_pkg::CH_SPACE);
        send_word(hrhp_pkg::OP_DATA, 8'h00);
        send_word(hrhp_pkg::OP_DATA, 8'hFF);
        send_word(hrhp_pkg::OP_DATA, hrhp_pkg::CH_SPACE);
        send_text("HTTP/1.1");
        send_crlf();
        send_word(hrhp_pkg::OP_DATA, hrhp_pkg::CH_CR);
        send_word(hrhp_pkg::OP_DATA, hrhp_pkg::CH_COLON);
        send_word(hrhp_pkg::OP_DATA, hrhp_pkg::CH_SPACE);
        send_word(hrhp_pkg::OP_DATA, 8'hFF);
        send_crlf();
        send_word(hrhp_pkg::OP_DATA, hrhp_pkg::CH_COLON);
        send_word(hrhp_pkg::OP_DATA, hrhp_pkg::CH_COLON);
        send_word(hrhp_pkg::OP_DATA, hrhp_pkg::CH_SPACE);
        send_crlf();
        send_crlf();
        send_word(hrhp_pkg::OP_DATA, 8'hFF);
        send_word(hrhp_pkg::OP_CLOSED, 8'hFF);
        send_word(hrhp_pkg::OP_UNUSED, 8'hFF);
    endtask

    // Version and request line mismatches, connection drop mid-head
    task automatic test_bad_request_line();
        send_word(hrhp_pkg::OP_BEGIN, 8'hFF);
        send_text("  HTTP/2");
        send_word(hrhp_pkg::OP_DATA, 8'h41);
        send_word(hrhp_pkg::OP_CLOSED, 8'h00);
        send_word(hrhp_pkg::OP_BEGIN, 8'h00);
        send_text("  HTTP/1.1X");
        send_word(hrhp_pkg::OP_BEGIN, 8'h00);
        send_text("GET");
        send_word(hrhp_pkg::OP_CLOSED, 8'h00);
        send_word(hrhp_pkg::OP_UNUSED, 8'h00);
    endtask

    // Method, resource, and the first header's name and value at full length
    task automatic test_long_fields();
        send_request(2, 1'b1, 1'b0);
    endtask

    // A full table, then one header more than the table holds, with short fields
    task automatic test_header_overflow();
        short_fields = 1'b1;
        send_request(hrhp_pkg::HEADER_ENTRIES_DEF, 1'b0, 1'b0);
        send_request(hrhp_pkg::HEADER_ENTRIES_DEF + 1, 1'b0, 1'b0);
        short_fields = 1'b0;
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (4)
            send_request($urandom_range(0, 4), 1'b0, 1'b0);
        idle_on = 1'b1;
    endtask

    // Output held off while input keeps coming
    task automatic test_backpressure();
        idle_on = 1'b0;
        stall_req++;
        send_request(4, 1'b0, 1'b0);
        idle_on = 1'b1;
    endtask

    // Random requests and noise until the word budget is spent
    task automatic test_random_heads();
        int r;
        int n_hdr;
        while (sent_words < TOTAL_WORDS) begin
            r = $urandom_range(0, 99);
            n_hdr = $urandom_range(0, 99);
            n_hdr = (n_hdr < 5) ? hrhp_pkg::HEADER_ENTRIES_DEF + 1 :
                    (n_hdr < 9) ? hrhp_pkg::HEADER_ENTRIES_DEF : $urandom_range(0, 4);
            short_fields = (n_hdr >= hrhp_pkg::HEADER_ENTRIES_DEF);
            if (r < 10)
                send_noise($urandom_range(3, 15));
            else
                send_request(n_hdr, r < 13, r >= 13 && r < 28);
            short_fields = 1'b0;
        end
    endtask

    // Receiver: random stalls, plus a long hold on request
    always @(negedge clk) begin
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            tag_ch.ready <= 1'b0;
        end else begin
            tag_ch.ready <= !(idle_on && $urandom_range(0, 99) < 21);
        end
    end

    function automatic string tag_text(input t_tag t);
        return $sformatf("kind %0d idx %0d off %0d val %02h st %0d",
                         t.kind, t.hidx, t.off, t.val, t.status);
    endfunction

    task automatic report_tag(input string what, input t_tag want, input t_tag got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s: want %s, got %s", what, tag_text(want), tag_text(got));
    endtask

    // Compare each accepted tag with the oldest expected one
    always @(posedge clk) begin : check_tags
        t_tag got;
        t_tag want;
        if (rst_n && tag_ch.valid && tag_ch.ready) begin
            got.kind   = tag_ch.field_kind;
            got.hidx   = tag_ch.header_index;
            got.off    = tag_ch.char_offset;
            got.val    = tag_ch.char_value;
            got.status = tag_ch.parse_status;
            if (expected_tags.size() == 0) begin
                report_tag("unexpected word", '0, got);
            end else begin
                want = expected_tags.pop_front();
                if (got.kind !== want.kind || got.hidx !== want.hidx ||
                    got.off !== want.off || got.val !== want.val ||
                    got.status !== want.status)
                    report_tag("tag mismatch", want, got);
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (tag_ch.valid && tag_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STUCK_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.op        = hrhp_pkg::OP_DATA;
        byte_ch.data_byte = '0;
        tag_ch.ready      = 1'b0;
        mismatch_count    = 0;
        sent_words        = 0;
        idle_cycles       = 0;
        idle_on           = 1'b1;
        short_fields      = 1'b0;
        stall_req         = 0;
        stall_seen        = 0;
        hold_left         = 0;
        clear_parse();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_head();
        test_bad_request_line();
        test_long_fields();
        test_header_overflow();
        test_back_to_back();
        test_backpressure();
        test_random_heads();

        // Drop valid and drain
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (expected_tags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
src/hrhp_pkg.sv
src/hrhp_if.sv
src/http_request_head_parser.sv
tb/tb.sv
